// File: design/sobel_pkg.sv
package sobel_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 4096;
  localparam int AddrW      = $clog2(MaxWidth);
  localparam int FifoDepth  = 8;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = FifoPtrW + 1;

  localparam logic [10:0] WidthMin  = 11'd3;
  localparam logic [10:0] WidthMax  = 11'd1024;
  localparam logic [12:0] HeightMin = 13'd3;
  localparam logic [12:0] HeightMax = 13'd4096;
  localparam logic [10:0] WidthRst  = 11'd640;
  localparam logic [12:0] HeightRst = 13'd480;

  localparam logic [7:0] HiThresh = 8'd200;
  localparam logic [7:0] LoThresh = 8'd100;
  localparam logic [7:0] PixMax   = 8'd255;

  localparam logic CfgImageWidth  = 1'b0;
  localparam logic CfgImageHeight = 1'b1;

  typedef logic [7:0] pix_t;
  typedef pix_t [8:0] win_t;

  typedef struct packed {
    logic        prod;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } tag_t;

  typedef struct packed {
    logic [7:0]  edge_value;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } result_t;

  typedef struct packed {
    logic s2_prod;
    logic s3_prod;
  } grad_status_t;

endpackage

// File: design/sobel_edge_threshold.sv
// sobel 3x3 edge detector with inverted, thresholded output
//
// in_*  : one grey pixel per beat in raster order, accepted when in_valid is
//         high and in_stall is low
// out_* : one beat per interior pixel carrying the edge value, the centre's
//         row and column, and out_last on the final interior pixel
// cfg_* : register writes, cfg_index 0 = image width, 1 = image height;
//         cfg_ready is always high, write only while the block is idle
//
// throughput is one pixel per clock while in_stall is low; the two line stores share one
// dual-port memory read and written once per pixel
// a result reaches out_* via the line-store read and input registers, then the
// window, gradient and queue registers, once its last window pixel is accepted
// a stalled receiver fills an 8-beat output queue; in_stall rises once the
// queue plus the results still in flight would fill it
// reset clears the counters, window and queue and sets width 640, height
// 480; line store contents are not cleared
module sobel_edge_threshold (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_edge_value,
  output logic [11:0] out_row,
  output logic [9:0]  out_col,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [10:0] w_eff;
  logic [12:0] h_eff;
  logic [9:0]  col_r;
  logic [9:0]  col_nxt;
  logic [11:0] row_r;
  logic [11:0] row_nxt;
  logic        col_end;
  logic        row_end;
  logic        accept;
  logic        v1_r;
  sobel_pkg::tag_t tag1_r;
  sobel_pkg::tag_t tag_nxt;
  logic [9:0]  addr1_r;
  sobel_pkg::pix_t px1_r;
  logic [15:0] rd_data;
  logic        push;
  sobel_pkg::result_t push_data;
  sobel_pkg::result_t head;
  sobel_pkg::grad_status_t gstat;
  logic [sobel_pkg::FifoCntW-1:0] fifo_cnt;
  logic [sobel_pkg::FifoCntW:0]   occ;
  logic        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sobel_pkg::WidthRst;
      height_r <= sobel_pkg::HeightRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sobel_pkg::CfgImageWidth:  width_r  <= cfg_data[10:0];
        sobel_pkg::CfgImageHeight: height_r <= cfg_data;
        default:                   width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    priority if (width_r < sobel_pkg::WidthMin) begin
      w_eff = sobel_pkg::WidthMin;
    end else if (width_r > sobel_pkg::WidthMax) begin
      w_eff = sobel_pkg::WidthMax;
    end else begin
      w_eff = width_r;
    end
    priority if (height_r < sobel_pkg::HeightMin) begin
      h_eff = sobel_pkg::HeightMin;
    end else if (height_r > sobel_pkg::HeightMax) begin
      h_eff = sobel_pkg::HeightMax;
    end else begin
      h_eff = height_r;
    end
  end

  // credit check against the output queue
  assign occ      = {1'b0, fifo_cnt} + {{sobel_pkg::FifoCntW{1'b0}}, v1_r && tag1_r.prod}
                  + {{sobel_pkg::FifoCntW{1'b0}}, gstat.s2_prod}
                  + {{sobel_pkg::FifoCntW{1'b0}}, gstat.s3_prod};
  assign in_stall = (occ >= (sobel_pkg::FifoCntW + 1)'(sobel_pkg::FifoDepth));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    col_end = ({1'b0, col_r} + 11'd1) >= w_eff;
    row_end = ({1'b0, row_r} + 13'd1) >= h_eff;
    col_nxt = col_end ? 10'd0 : col_r + 10'd1;
    row_nxt = col_end ? (row_end ? 12'd0 : row_r + 12'd1) : row_r;
    tag_nxt.prod = (row_r >= 12'd2) && (col_r >= 10'd2);
    tag_nxt.row  = row_r - 12'd1;
    tag_nxt.col  = col_r - 10'd1;
    tag_nxt.last = row_end && col_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      v1_r  <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag1_r  <= tag_nxt;
      addr1_r <= col_r;
      px1_r   <= in_pixel;
    end
  end

  // read at accept, shift the pair down one line on the next cycle
  sobel_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (v1_r),
    .wr_addr (addr1_r),
    .wr_data ({rd_data[7:0], px1_r})
  );

  sobel_grad u_grad (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (v1_r),
    .s1_tag    (tag1_r),
    .up_pix    (rd_data[15:8]),
    .mid_pix   (rd_data[7:0]),
    .new_pix   (px1_r),
    .push      (push),
    .push_data (push_data),
    .status    (gstat)
  );

  assign pop = out_valid && !out_stall;

  sobel_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (out_valid),
    .head      (head),
    .count     (fifo_cnt)
  );

  assign out_edge_value = head.edge_value;
  assign out_row        = head.row;
  assign out_col        = head.col;
  assign out_last       = head.last;

endmodule

// File: design/sobel_line_mem.sv
module sobel_line_mem (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [sobel_pkg::AddrW-1:0]  rd_addr,
  output logic [15:0]                  rd_data,
  input  logic                         wr_en,
  input  logic [sobel_pkg::AddrW-1:0]  wr_addr,
  input  logic [15:0]                  wr_data
);

  // entry holds {older line, newer line}
  logic [15:0] mem [sobel_pkg::MaxWidth];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/sobel_grad.sv
module sobel_grad (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    s1_valid,
  input  sobel_pkg::tag_t         s1_tag,
  input  sobel_pkg::pix_t         up_pix,
  input  sobel_pkg::pix_t         mid_pix,
  input  sobel_pkg::pix_t         new_pix,
  output logic                    push,
  output sobel_pkg::result_t      push_data,
  output sobel_pkg::grad_status_t status
);

  sobel_pkg::win_t   win_r;
  sobel_pkg::win_t   win_nxt;
  logic              v2_r;
  sobel_pkg::tag_t   tag2_r;
  logic              v3_r;
  sobel_pkg::tag_t   tag3_r;
  logic signed [10:0] gx_r;
  logic signed [10:0] gy_r;
  logic signed [10:0] gx_nxt;
  logic signed [10:0] gy_nxt;
  logic [9:0]  sum_xp, sum_xn, sum_yp, sum_yn;
  logic [9:0]  abs_x, abs_y;
  logic [10:0] mag;
  logic [7:0]  inv;
  logic [7:0]  edge_thr;

  // window column shift, newest column on the right
  always_comb begin
    win_nxt = win_r;
    for (int k = 0; k < 3; k++) begin
      win_nxt[k*3 + 0] = win_r[k*3 + 1];
      win_nxt[k*3 + 1] = win_r[k*3 + 2];
    end
    win_nxt[2] = up_pix;
    win_nxt[5] = mid_pix;
    win_nxt[8] = new_pix;
  end

  always_comb begin
    sum_xp = {2'b0, win_r[2]} + {1'b0, win_r[5], 1'b0} + {2'b0, win_r[8]};
    sum_xn = {2'b0, win_r[0]} + {1'b0, win_r[3], 1'b0} + {2'b0, win_r[6]};
    sum_yp = {2'b0, win_r[0]} + {1'b0, win_r[1], 1'b0} + {2'b0, win_r[2]};
    sum_yn = {2'b0, win_r[6]} + {1'b0, win_r[7], 1'b0} + {2'b0, win_r[8]};
    gx_nxt = $signed({1'b0, sum_xp}) - $signed({1'b0, sum_xn});
    gy_nxt = $signed({1'b0, sum_yp}) - $signed({1'b0, sum_yn});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      if (s1_valid) begin
        win_r <= win_nxt;
      end
      v2_r <= s1_valid;
      v3_r <= v2_r && tag2_r.prod;
    end
  end

  always_ff @(posedge clk) begin
    tag2_r <= s1_tag;
    tag3_r <= tag2_r;
    gx_r   <= gx_nxt;
    gy_r   <= gy_nxt;
  end

  always_comb begin
    abs_x = gx_r[10] ? 10'(-gx_r) : gx_r[9:0];
    abs_y = gy_r[10] ? 10'(-gy_r) : gy_r[9:0];
    mag   = {1'b0, abs_x} + {1'b0, abs_y};
    inv   = sobel_pkg::PixMax - mag[7:0];
    priority if (inv > sobel_pkg::HiThresh) begin
      edge_thr = sobel_pkg::PixMax;
    end else if (inv < sobel_pkg::LoThresh) begin
      edge_thr = 8'd0;
    end else begin
      edge_thr = inv;
    end
  end

  assign push                 = v3_r;
  assign push_data.edge_value = edge_thr;
  assign push_data.row        = tag3_r.row;
  assign push_data.col        = tag3_r.col;
  assign push_data.last       = tag3_r.last;
  assign status.s2_prod       = v2_r && tag2_r.prod;
  assign status.s3_prod       = v3_r;

endmodule

// File: design/sobel_out_fifo.sv
module sobel_out_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  sobel_pkg::result_t              push_data,
  input  logic                            pop,
  output logic                            not_empty,
  output sobel_pkg::result_t              head,
  output logic [sobel_pkg::FifoCntW-1:0]  count
);

  sobel_pkg::result_t                    ent_r [sobel_pkg::FifoDepth];
  logic [sobel_pkg::FifoPtrW-1:0]        wr_ptr_r;
  logic [sobel_pkg::FifoPtrW-1:0]        rd_ptr_r;
  logic [sobel_pkg::FifoCntW-1:0]        cnt_r;
  logic [sobel_pkg::FifoCntW-1:0]        cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (cnt_r != '0);
  assign head      = ent_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

// File: sim/sobel_edge_threshold_tb.sv
`timescale 1ns / 1ps

module sobel_edge_threshold_tb;
  import sobel_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int RandomPixels = 1250;
  localparam int SettleCycles = 12;

  typedef struct packed {
    pix_t px;
    logic known;
    pix_t edge_v;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_pixel = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_edge_value;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CfgImageWidth;
  logic [12:0] cfg_data = '0;

  // mirror of the block: line stores, window, raster counters, registers
  pix_t        line_old [MaxWidth];
  pix_t        line_new [MaxWidth];
  pix_t        nbhd [9];
  int          col_at;
  int          row_at;
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  result_t     pending_edges [$];
  result_t     oldest_edge;

  int  cycle_count = 0;
  int  mismatch_count = 0;
  int  edges_checked = 0;
  int  pixels_sent = 0;
  int  images_done = 0;
  int  burst_left = 0;
  bit  hold_due = 1'b0;

  // three columns, eight rows: flat, step edges, then mixed content
  stim_row_t corner_rows [24] = '{
    '{8'd0, 1'b0, 8'd0},     '{8'd0, 1'b0, 8'd0},     '{8'd0, 1'b0, 8'd0},
    '{8'd0, 1'b0, 8'd0},     '{8'd0, 1'b0, 8'd0},     '{8'd0, 1'b0, 8'd0},
    '{8'd0, 1'b0, 8'd0},     '{8'd0, 1'b0, 8'd0},     '{8'd0, 1'b1, 8'd255},
    '{8'd255, 1'b0, 8'd0},   '{8'd255, 1'b0, 8'd0},   '{8'd255, 1'b1, 8'd0},
    '{8'd255, 1'b0, 8'd0},   '{8'd255, 1'b0, 8'd0},   '{8'd255, 1'b1, 8'd0},
    '{8'd255, 1'b0, 8'd0},   '{8'd255, 1'b0, 8'd0},   '{8'd255, 1'b1, 8'd255},
    '{8'd0, 1'b0, 8'd0},     '{8'd128, 1'b0, 8'd0},   '{8'd255, 1'b0, 8'd0},
    '{8'd255, 1'b0, 8'd0},   '{8'd64, 1'b0, 8'd0},    '{8'd1, 1'b0, 8'd0}
  };

  sobel_edge_threshold uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_edge_value (out_edge_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_edges.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int eff_width();
    if (width_reg < WidthMin) return WidthMin;
    if (width_reg > WidthMax) return WidthMax;
    return width_reg;
  endfunction

  function automatic int eff_height();
    if (height_reg < HeightMin) return HeightMin;
    if (height_reg > HeightMax) return HeightMax;
    return height_reg;
  endfunction

  // shift one pixel into the window and work out the edge result it completes
  function automatic bit step_window(input pix_t px, output result_t res);
    int   w, h, gx, gy, mag;
    int   t [9];
    pix_t inv;
    bit   made;
    w = eff_width();
    h = eff_height();
    res = '0;
    made = 1'b0;
    for (int k = 0; k < 3; k++) begin
      nbhd[k*3]   = nbhd[k*3+1];
      nbhd[k*3+1] = nbhd[k*3+2];
    end
    nbhd[2] = line_old[col_at];
    nbhd[5] = line_new[col_at];
    nbhd[8] = px;
    line_old[col_at] = line_new[col_at];
    line_new[col_at] = px;
    foreach (t[k]) t[k] = nbhd[k];
    if (row_at >= 2 && col_at >= 2) begin
      gx  = (t[2] + 2 * t[5] + t[8]) - (t[0] + 2 * t[3] + t[6]);
      gy  = (t[0] + 2 * t[1] + t[2]) - (t[6] + 2 * t[7] + t[8]);
      mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      inv = PixMax - pix_t'(mag);
      if (inv > HiThresh) inv = PixMax;
      else if (inv < LoThresh) inv = '0;
      res.edge_value = inv;
      res.row  = 12'(row_at - 1);
      res.col  = 10'(col_at - 1);
      res.last = (row_at + 1 >= h) && (col_at + 1 >= w);
      made = 1'b1;
    end
    if (col_at + 1 >= w) begin
      col_at = 0;
      row_at = (row_at + 1 >= h) ? 0 : row_at + 1;
    end else begin
      col_at++;
    end
    return made;
  endfunction

  function automatic pix_t texture(input int style, input int r, input int c);
    case (style)
      0:       return pix_t'($urandom_range(0, 255));
      1:       return pix_t'(96 + $urandom_range(0, 6));
      2:       return ($urandom_range(0, 1) != 0) ? PixMax : 8'd0;
      default: return pix_t'(r * 9 + c * 5 + $urandom_range(0, 12));
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("ERROR cycle %0d: %s", cycle_count, what);
  endtask

  task automatic send_pixel(input pix_t px, input bit known = 1'b0, input pix_t edge_v = '0);
    result_t res;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    pixels_sent++;
    if (step_window(px, res)) begin
      if (known) res.edge_value = edge_v;
      pending_edges.push_back(res);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [12:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CfgImageWidth) width_reg = data[10:0];
    else height_reg = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender pauses until every pending beat is out and the pipeline is empty
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic run_images(input logic [12:0] w_data, input logic [12:0] h_data,
                            input int count, input bit pressure);
    int w, h, style;
    drain();
    write_reg(CfgImageWidth, w_data);
    write_reg(CfgImageHeight, h_data);
    w = eff_width();
    h = eff_height();
    if (pressure) hold_due = 1'b1;
    repeat (count) begin
      style = $urandom_range(0, 3);
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++)
          send_pixel(texture(style, r, c));
      images_done++;
    end
  endtask

  // receiver stall pattern, with long hold-offs to back up the output queue
  initial begin
    int seg, pct, span;
    forever begin
      if (hold_due || $urandom_range(0, 40) == 0) begin
        span = hold_due ? 120 : $urandom_range(30, 90);
        hold_due = 1'b0;
        repeat (span) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        seg = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 20;
          2:       pct = 50;
          default: pct = 85;
        endcase
        for (int i = 0; i < seg && !hold_due; i++) begin
          @(negedge clk);
          out_stall <= ($urandom_range(0, 99) < pct);
        end
      end
    end
  end

  always @(posedge clk) begin
    string spot;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_edges.size() == 0) begin
        flag_mismatch($sformatf("beat at row %0d col %0d with nothing pending", out_row,
                                out_col));
      end else begin
        oldest_edge = pending_edges.pop_front();
        edges_checked++;
        spot = $sformatf("row %0d col %0d", oldest_edge.row, oldest_edge.col);
        if (out_edge_value !== oldest_edge.edge_value)
          flag_mismatch($sformatf("%s edge_value got %0d expected %0d", spot,
                                  out_edge_value, oldest_edge.edge_value));
        if (out_row !== oldest_edge.row)
          flag_mismatch($sformatf("%s out_row got %0d", spot, out_row));
        if (out_col !== oldest_edge.col)
          flag_mismatch($sformatf("%s out_col got %0d", spot, out_col));
        if (out_last !== oldest_edge.last)
          flag_mismatch($sformatf("%s out_last got %0b expected %0b", spot, out_last,
                                  oldest_edge.last));
      end
    end
  end

  initial begin
    logic [12:0] wd, ht;
    int          phase_idx, base_pixels;
    foreach (line_old[k]) begin
      line_old[k] = '0;
      line_new[k] = '0;
    end
    foreach (nbhd[k]) nbhd[k] = '0;
    col_at = 0;
    row_at = 0;
    width_reg  = WidthRst;
    height_reg = HeightRst;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CfgImageWidth, {2'b11, 11'd3});
    write_reg(CfgImageHeight, 13'd8);
    foreach (corner_rows[i])
      send_pixel(corner_rows[i].px, corner_rows[i].known, corner_rows[i].edge_v);
    images_done++;

    // cut the image short by lowering the height mid-image
    drain();
    write_reg(CfgImageWidth, 13'd5);
    write_reg(CfgImageHeight, 13'd4000);
    repeat (2 * 5) send_pixel(texture(0, 0, 0));
    drain();
    write_reg(CfgImageHeight, 13'd3);
    repeat (5) send_pixel(texture(0, 0, 0));
    images_done++;

    phase_idx = 0;
    base_pixels = pixels_sent;
    while (pixels_sent - base_pixels < RandomPixels) begin
      if (phase_idx == 0) begin
        run_images(13'd32, 13'd8, 1, 1'b1);
      end else begin
        if ($urandom_range(0, 9) == 0)
          wd = {2'($urandom_range(0, 3)), 11'($urandom_range(0, 2))};
        else if ($urandom_range(0, 7) == 0)
          wd = {2'($urandom_range(0, 3)), 11'($urandom_range(17, 40))};
        else
          wd = {2'($urandom_range(0, 3)), 11'($urandom_range(3, 16))};
        ht = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 2))
                                         : 13'($urandom_range(3, 8));
        run_images(wd, ht, $urandom_range(1, 2), 1'b0);
      end
      phase_idx++;
    end
    drain();

    $display("sent %0d pixels in %0d small images, with clamped low sizes, ignored upper",
             pixels_sent, images_done);
    $display("register bits and a mid-image height cut; %0d edge beats checked, %0d mismatches",
             edges_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
